// ----- design/rau_pkg.sv -----
// Shared codes, constants and handshake types of the rational arithmetic unit.
package rau_pkg;

  localparam int WORD_BITS_DEF = 64;

  localparam logic [3:0] MODE_ADD    = 4'd0;
  localparam logic [3:0] MODE_SUB    = 4'd1;
  localparam logic [3:0] MODE_MUL    = 4'd2;
  localparam logic [3:0] MODE_DIV    = 4'd3;
  localparam logic [3:0] MODE_EQ     = 4'd4;
  localparam logic [3:0] MODE_NE     = 4'd5;
  localparam logic [3:0] MODE_LT     = 4'd6;
  localparam logic [3:0] MODE_LE     = 4'd7;
  localparam logic [3:0] MODE_GT     = 4'd8;
  localparam logic [3:0] MODE_GE     = 4'd9;
  localparam logic [3:0] MODE_REDUCE = 4'd10;
  localparam logic [3:0] MODE_EXPAND = 4'd11;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_ZERODEN = 2'd1;
  localparam logic [1:0] ST_OVF     = 2'd2;

  typedef enum logic {
    UOP_MUL,
    UOP_DIV
  } uop_t;

  typedef struct packed {
    logic start;
    uop_t op;
  } rau_req_t;

  typedef struct packed {
    logic done;
    logic ovf;
  } rau_rsp_t;

endpackage

// ----- design/rau_unit.sv -----
// Shared shift-add multiplier and restoring divider, one bit per cycle.
module rau_unit import rau_pkg::*; #(
  parameter int W = WORD_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  rau_req_t         req,
  input  logic [W-1:0]     a,
  input  logic [W-1:0]     b,
  output rau_rsp_t         rsp,
  output logic [W-1:0]     res,
  output logic [W-1:0]     rem,
  output logic [2*W-1:0]   prod
);

  localparam int CW = $clog2(W + 1);
  localparam logic [W-1:0] SIGN_W = {1'b1, {(W-1){1'b0}}};

  logic          busy_r, done_r, ovf_r, neg_r, aneg_r;
  uop_t          op_r;
  logic [CW-1:0] cnt_r;
  logic [W-1:0]  ma_r, lo_r, res_r, rem_r;
  logic [W:0]    hi_r;
  logic [2*W-1:0] prod_r;

  logic [W-1:0] mag_a, mag_b, limit;
  logic [W:0]   sum, shifted;
  logic         fit;

  always_comb begin
    mag_a   = a[W-1] ? (~a + 1'b1) : a;
    mag_b   = b[W-1] ? (~b + 1'b1) : b;
    sum     = {1'b0, hi_r[W-1:0]} + (lo_r[0] ? {1'b0, ma_r} : '0);
    shifted = {hi_r[W-1:0], lo_r[W-1]};
    fit     = shifted >= {1'b0, ma_r};
    limit   = neg_r ? SIGN_W : SIGN_W - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        op_r   <= req.op;
        neg_r  <= a[W-1] ^ b[W-1];
        aneg_r <= a[W-1];
        hi_r   <= '0;
        cnt_r  <= CW'(W);
        if (req.op == UOP_MUL) begin
          ma_r <= mag_a;
          lo_r <= mag_b;
        end else begin
          ma_r <= mag_b;
          lo_r <= mag_a;
        end
        if (req.op == UOP_DIV && b == '0) begin
          res_r  <= '0;
          rem_r  <= '0;
          done_r <= 1'b1;
        end else begin
          busy_r <= 1'b1;
        end
      end else if (busy_r) begin
        if (cnt_r != '0) begin
          cnt_r <= cnt_r - 1'b1;
          if (op_r == UOP_MUL) begin
            hi_r <= {1'b0, sum[W:1]};
            lo_r <= {sum[0], lo_r[W-1:1]};
          end else begin
            hi_r <= fit ? shifted - {1'b0, ma_r} : shifted;
            lo_r <= {lo_r[W-2:0], fit};
          end
        end else begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
          if (op_r == UOP_MUL) begin
            prod_r <= {hi_r[W-1:0], lo_r};
            res_r  <= neg_r ? (~lo_r + 1'b1) : lo_r;
            ovf_r  <= (hi_r[W-1:0] != '0) || (lo_r > limit);
          end else begin
            res_r <= neg_r ? (~lo_r + 1'b1) : lo_r;
            rem_r <= aneg_r ? (~hi_r[W-1:0] + 1'b1) : hi_r[W-1:0];
          end
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.ovf  = ovf_r;
  assign res      = res_r;
  assign rem      = rem_r;
  assign prod     = prod_r;

endmodule

// ----- design/rational_arithmetic_unit.sv -----
// Top level: rational arithmetic sequencer over a shared multiply/divide unit.
// Input channel in_*: one request carries mode in in_tuser and the two
// fractions in in_tdata. The block takes one request at a time; in_tready is
// high only while the sequencer is idle.
// Output channel out_*: one result per request, fraction and truth bit in
// out_tdata, status in out_tuser.
// Every multiply or divide step runs in the shared bit-serial unit.
// Comparisons take two products, expand two products, reduce one GCD plus
// two divisions, add and subtract a GCD plus six steps, multiply two GCDs
// plus six steps; equal denominators, an integer second factor, or signs and
// zeros that settle a comparison take shorter paths. A GCD costs one
// division per Euclid iteration, so a request's time is data dependent.
// Requests do not overlap in the sequencer; a new request may be
// taken while the previous result still waits in the output register.
// Reset clears the sequencer and drops out_tvalid. A stalled receiver holds
// the result; a finished computation waits until the output register is free.
module rational_arithmetic_unit import rau_pkg::*; #(
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [255:0] in_tdata,   // a_num, a_den, b_num, b_den
  input  logic [3:0]   in_tuser,   // mode
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [135:0] out_tdata,  // res_num, res_den, truth, zero pad
  output logic [1:0]   out_tuser   // status
);

  localparam int W = WORD_BITS;

  typedef enum logic [4:0] {
    S_IDLE, S_CHECK, S_WAIT, S_GCD, S_GCD_STEP,
    S_AS_G, S_AS_L, S_AS_T1, S_AS_PA, S_AS_T2, S_AS_PB, S_AS_END,
    S_MF, S_MF_INT, S_MF_G1, S_MF_XN, S_MF_XD, S_MF_G2, S_MF_YN, S_MF_YD,
    S_MF_P1, S_MF_P2,
    S_RD_G, S_RD_N, S_RD_D, S_EX_N, S_EX_D,
    S_CMP1, S_CMP2, S_CMP_END, S_FIN
  } state_t;

  state_t state_r, state_nxt, ret_r, ret_nxt, gret_r, gret_nxt;
  logic [3:0]   mode_r, mode_nxt;
  logic [W-1:0] an_r, ad_r, bn_r, bd_r, an_nxt, ad_nxt, bn_nxt, bd_nxt;
  logic [W-1:0] x_r, y_r, x_nxt, y_nxt;
  logic [W-1:0] t1_r, t2_r, t3_r, t1_nxt, t2_nxt, t3_nxt;
  logic [W-1:0] rn_r, rd_r, rn_nxt, rd_nxt;
  logic [2*W-1:0] p1_r, p1_nxt;
  logic [1:0]   status_r, status_nxt;
  logic         truth_r, truth_nxt, lt_r, lt_nxt, eq_r, eq_nxt, ovf_r, ovf_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic [135:0]  out_data_r, out_data_nxt;
  logic [1:0]    out_user_r, out_user_nxt;

  rau_req_t       u_req;
  rau_rsp_t       u_rsp;
  logic [W-1:0]   u_a, u_b, u_res, u_rem;
  logic [2*W-1:0] u_prod;

  rau_unit #(.W(W)) u_unit (
    .clk(clk), .rst_n(rst_n), .req(u_req), .a(u_a), .b(u_b),
    .rsp(u_rsp), .res(u_res), .rem(u_rem), .prod(u_prod)
  );

  logic sa_zero, sa_neg, sb_zero, sb_neg, arith, ltc, eqc;
  logic [W-1:0] fin_rn, fin_rd;
  logic [1:0]   fin_st;
  logic         fin_truth;
  logic signed [63:0] rn_ext, rd_ext;

  function automatic logic cmp_truth(input logic [3:0] m, input logic lt, input logic eq);
    logic t;
    case (m)
      MODE_EQ: t = eq;
      MODE_NE: t = !eq;
      MODE_LT: t = lt;
      MODE_LE: t = lt || eq;
      MODE_GT: t = !lt && !eq;
      MODE_GE: t = !lt;
      default: t = 1'b0;
    endcase
    return t;
  endfunction

  always_comb begin
    state_nxt = state_r;  ret_nxt = ret_r;  gret_nxt = gret_r;
    mode_nxt = mode_r;
    an_nxt = an_r;  ad_nxt = ad_r;  bn_nxt = bn_r;  bd_nxt = bd_r;
    x_nxt = x_r;  y_nxt = y_r;
    t1_nxt = t1_r;  t2_nxt = t2_r;  t3_nxt = t3_r;
    rn_nxt = rn_r;  rd_nxt = rd_r;  p1_nxt = p1_r;
    status_nxt = status_r;  truth_nxt = truth_r;
    lt_nxt = lt_r;  eq_nxt = eq_r;  ovf_nxt = ovf_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt = out_data_r;
    out_user_nxt = out_user_r;
    u_req.start = 1'b0;  u_req.op = UOP_MUL;
    u_a = an_r;  u_b = bd_r;

    sa_zero = an_r == '0;
    sa_neg  = !sa_zero && (an_r[W-1] ^ ad_r[W-1]);
    sb_zero = bn_r == '0;
    sb_neg  = !sb_zero && (bn_r[W-1] ^ bd_r[W-1]);
    arith   = mode_r inside {[MODE_ADD:MODE_DIV], MODE_REDUCE, MODE_EXPAND};
    ltc = p1_r < u_prod;
    eqc = p1_r == u_prod;

    fin_st = status_r;
    if (status_r == ST_OK && arith && rd_r == '0) fin_st = ST_ZERODEN;
    fin_rn    = (fin_st == ST_OK) ? rn_r : '0;
    fin_rd    = (fin_st == ST_OK) ? rd_r : '0;
    fin_truth = (fin_st == ST_OK) && truth_r;
    rn_ext = 64'(signed'(fin_rn));
    rd_ext = 64'(signed'(fin_rd));

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          mode_nxt = in_tuser;
          an_nxt = in_tdata[W-1:0];
          ad_nxt = in_tdata[64 +: W];
          bn_nxt = in_tdata[128 +: W];
          bd_nxt = in_tdata[192 +: W];
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        rn_nxt = '0;  rd_nxt = '0;  truth_nxt = 1'b0;  status_nxt = ST_OK;
        ovf_nxt = 1'b0;
        state_nxt = S_FIN;
        if (mode_r > MODE_EXPAND) begin
          state_nxt = S_FIN;
        end else if (ad_r == '0 || (mode_r != MODE_REDUCE && bd_r == '0)) begin
          status_nxt = ST_ZERODEN;
        end else begin
          case (mode_r)
            MODE_ADD, MODE_SUB: begin
              if (ad_r == bd_r) begin
                rn_nxt = (mode_r == MODE_SUB) ? an_r - bn_r : an_r + bn_r;
                rd_nxt = ad_r;
              end else begin
                x_nxt = ad_r;  y_nxt = bd_r;  gret_nxt = S_AS_G;
                state_nxt = S_GCD;
              end
            end
            MODE_MUL: state_nxt = S_MF;
            MODE_DIV: begin
              if (bn_r == '0) begin
                status_nxt = ST_ZERODEN;
              end else if (ad_r == bd_r) begin
                rn_nxt = an_r;  rd_nxt = bn_r;
              end else begin
                bn_nxt = bd_r;  bd_nxt = bn_r;
                state_nxt = S_MF;
              end
            end
            MODE_REDUCE: begin
              x_nxt = an_r;  y_nxt = ad_r;  gret_nxt = S_RD_G;
              state_nxt = S_GCD;
            end
            MODE_EXPAND: begin
              u_req.start = 1'b1;  u_a = an_r;  u_b = bd_r;
              ret_nxt = S_EX_N;  state_nxt = S_WAIT;
            end
            default: begin
              if (sa_zero && sb_zero) begin
                lt_nxt = 1'b0;  eq_nxt = 1'b1;  state_nxt = S_CMP_END;
              end else if (sa_zero != sb_zero || sa_neg != sb_neg) begin
                lt_nxt = sa_neg || (sa_zero && !sb_neg);
                eq_nxt = 1'b0;  state_nxt = S_CMP_END;
              end else begin
                u_req.start = 1'b1;  u_a = an_r;  u_b = bd_r;
                ret_nxt = S_CMP1;  state_nxt = S_WAIT;
              end
            end
          endcase
        end
      end
      S_WAIT: if (u_rsp.done) state_nxt = ret_r;
      S_GCD: begin
        if (y_r == '0) begin
          state_nxt = gret_r;
        end else begin
          u_req.start = 1'b1;  u_req.op = UOP_DIV;  u_a = x_r;  u_b = y_r;
          ret_nxt = S_GCD_STEP;  state_nxt = S_WAIT;
        end
      end
      S_GCD_STEP: begin
        x_nxt = y_r;  y_nxt = u_rem;  state_nxt = S_GCD;
      end
      S_AS_G: begin
        u_req.start = 1'b1;  u_req.op = UOP_DIV;  u_a = bd_r;  u_b = x_r;
        ret_nxt = S_AS_L;  state_nxt = S_WAIT;
      end
      S_AS_L: begin
        u_req.start = 1'b1;  u_a = ad_r;  u_b = u_res;
        ret_nxt = S_AS_T1;  state_nxt = S_WAIT;
      end
      S_AS_T1: begin
        t1_nxt = u_res;
        u_req.start = 1'b1;  u_req.op = UOP_DIV;  u_a = u_res;  u_b = ad_r;
        ret_nxt = S_AS_PA;  state_nxt = S_WAIT;
      end
      S_AS_PA: begin
        u_req.start = 1'b1;  u_a = an_r;  u_b = u_res;
        ret_nxt = S_AS_T2;  state_nxt = S_WAIT;
      end
      S_AS_T2: begin
        t2_nxt = u_res;
        u_req.start = 1'b1;  u_req.op = UOP_DIV;  u_a = t1_r;  u_b = bd_r;
        ret_nxt = S_AS_PB;  state_nxt = S_WAIT;
      end
      S_AS_PB: begin
        u_req.start = 1'b1;  u_a = bn_r;  u_b = u_res;
        ret_nxt = S_AS_END;  state_nxt = S_WAIT;
      end
      S_AS_END: begin
        rn_nxt = (mode_r == MODE_SUB) ? t2_r - u_res : t2_r + u_res;
        rd_nxt = t1_r;
        state_nxt = S_FIN;
      end
      S_MF: begin
        if (bd_r == W'(1)) begin
          u_req.start = 1'b1;  u_a = an_r;  u_b = bn_r;
          ret_nxt = S_MF_INT;  state_nxt = S_WAIT;
        end else begin
          x_nxt = an_r;  y_nxt = ad_r;  gret_nxt = S_MF_G1;
          state_nxt = S_GCD;
        end
      end
      S_MF_INT: begin
        rn_nxt = u_res;  rd_nxt = ad_r;  state_nxt = S_FIN;
      end
      S_MF_G1: begin
        t3_nxt = x_r;
        u_req.start = 1'b1;  u_req.op = UOP_DIV;  u_a = an_r;  u_b = x_r;
        ret_nxt = S_MF_XN;  state_nxt = S_WAIT;
      end
      S_MF_XN: begin
        t1_nxt = u_res;
        u_req.start = 1'b1;  u_req.op = UOP_DIV;  u_a = ad_r;  u_b = t3_r;
        ret_nxt = S_MF_XD;  state_nxt = S_WAIT;
      end
      S_MF_XD: begin
        t2_nxt = u_res;
        x_nxt = bn_r;  y_nxt = bd_r;  gret_nxt = S_MF_G2;
        state_nxt = S_GCD;
      end
      S_MF_G2: begin
        t3_nxt = x_r;
        u_req.start = 1'b1;  u_req.op = UOP_DIV;  u_a = bn_r;  u_b = x_r;
        ret_nxt = S_MF_YN;  state_nxt = S_WAIT;
      end
      S_MF_YN: begin
        t3_nxt = u_res;
        u_req.start = 1'b1;  u_req.op = UOP_DIV;  u_a = bd_r;  u_b = t3_r;
        ret_nxt = S_MF_YD;  state_nxt = S_WAIT;
      end
      S_MF_YD: begin
        bd_nxt = u_res;
        u_req.start = 1'b1;  u_a = t1_r;  u_b = t3_r;
        ret_nxt = S_MF_P1;  state_nxt = S_WAIT;
      end
      S_MF_P1: begin
        rn_nxt = u_res;  ovf_nxt = u_rsp.ovf;
        u_req.start = 1'b1;  u_a = t2_r;  u_b = bd_r;
        ret_nxt = S_MF_P2;  state_nxt = S_WAIT;
      end
      S_MF_P2: begin
        rd_nxt = u_res;
        if (ovf_r || u_rsp.ovf) status_nxt = ST_OVF;
        state_nxt = S_FIN;
      end
      S_RD_G: begin
        t3_nxt = x_r;
        u_req.start = 1'b1;  u_req.op = UOP_DIV;  u_a = an_r;  u_b = x_r;
        ret_nxt = S_RD_N;  state_nxt = S_WAIT;
      end
      S_RD_N: begin
        rn_nxt = u_res;
        u_req.start = 1'b1;  u_req.op = UOP_DIV;  u_a = ad_r;  u_b = t3_r;
        ret_nxt = S_RD_D;  state_nxt = S_WAIT;
      end
      S_RD_D: begin
        rd_nxt = u_res;  state_nxt = S_FIN;
      end
      S_EX_N: begin
        rn_nxt = u_res;
        u_req.start = 1'b1;  u_a = ad_r;  u_b = bd_r;
        ret_nxt = S_EX_D;  state_nxt = S_WAIT;
      end
      S_EX_D: begin
        rd_nxt = u_res;  state_nxt = S_FIN;
      end
      S_CMP1: begin
        p1_nxt = u_prod;
        u_req.start = 1'b1;  u_a = bn_r;  u_b = ad_r;
        ret_nxt = S_CMP2;  state_nxt = S_WAIT;
      end
      S_CMP2: begin
        eq_nxt = eqc;
        lt_nxt = sa_neg ? (!ltc && !eqc) : ltc;
        state_nxt = S_CMP_END;
      end
      S_CMP_END: begin
        truth_nxt = cmp_truth(mode_r, lt_r, eq_r);
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt = {7'd0, fin_truth, rd_ext, rn_ext};
          out_user_nxt = fin_st;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ret_r       <= S_IDLE;
      gret_r      <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ret_r       <= ret_nxt;
      gret_r      <= gret_nxt;
      out_valid_r <= out_valid_nxt;
    end
    mode_r <= mode_nxt;
    an_r <= an_nxt;  ad_r <= ad_nxt;  bn_r <= bn_nxt;  bd_r <= bd_nxt;
    x_r <= x_nxt;  y_r <= y_nxt;
    t1_r <= t1_nxt;  t2_r <= t2_nxt;  t3_r <= t3_nxt;
    rn_r <= rn_nxt;  rd_r <= rd_nxt;  p1_r <= p1_nxt;
    status_r <= status_nxt;  truth_r <= truth_nxt;
    lt_r <= lt_nxt;  eq_r <= eq_nxt;  ovf_r <= ovf_nxt;
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
  end

  assign in_tready  = state_r == S_IDLE;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request taken while busy");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != ST_OK |-> out_tdata == '0)
    else $error("error result carries data");

  a_truth_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[128] |-> out_tdata[127:0] == '0 && out_tuser == ST_OK)
    else $error("true comparison carries a fraction");

  a_unit_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
    u_req.start |=> state_r == S_WAIT)
    else $error("unit started outside a call");

endmodule
